/* hdl/ffra_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared types and status codes for the first-fit range allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

  localparam int ADDR_W = 48;
  localparam int SIZE_W = 32;
  localparam int PAGE_W = 16;
  localparam int ST_W   = 3;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_BAD_SIZE = 3'd1,
    ST_NO_FIT   = 3'd2,
    ST_FULL     = 3'd3,
    ST_INVALID  = 3'd4,
    ST_DOUBLE   = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SRCH_RD,
    S_SRCH_EV,
    S_SHR_RD,
    S_SHR_WR,
    S_SPLIT,
    S_NB_RD,
    S_NB_EV,
    S_SHL_RD,
    S_SHL_WR,
    S_DONE
  } state_t;

  // one span table entry
  typedef struct packed {
    logic [PAGE_W-1:0] start_pg;
    logic [PAGE_W-1:0] end_pg;
    logic              is_free;
  } span_t;

  localparam int SPAN_W = 2 * PAGE_W + 1;

endpackage

/* hdl/first_fit_range_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_range_allocator
// Address-ordered span table allocator: first-fit allocate with split,
// free with coalescing of both neighbours.
// ----------------------------------------------------------------------------
//  channel | dir | fields (low bit up)
//  in_     | in  | tuser: mode; tdata: size_bytes[31:0], free_address[47:0]
//  out_    | out | tdata: status[2:0], start_address[47:0] (51 -> 56 bits)
//  cfg_    | in  | region_base[47:0]
//
// One request at a time. The table scan takes a read and an evaluate step
// per live span on the single-port span RAM, and each entry shifted on a
// split or merge takes a read and a write step. Reset entries beyond the
// fill count are never read, so no clearing pass is needed; reset is
// synchronous, active low, and leaves one free span covering the region.
// A stalled result holds in the output register; the next request is taken
// only once it has been transferred.
// ----------------------------------------------------------------------------
module first_fit_range_allocator #(
  parameter int REGION_PAGES = 32768,
  parameter int MAX_SPANS    = 64,
  parameter int PAGE_BYTES   = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,  // mode
  input  logic [79:0] in_tdata,  // size_bytes, free_address
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata, // status, start_address
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [47:0] cfg_data
);
  import ffra_pkg::*;

  localparam int IDX_W = $clog2(MAX_SPANS);
  localparam int CNT_W = $clog2(MAX_SPANS + 1);
  localparam int PSH   = $clog2(PAGE_BYTES);
  localparam int PGS_W = SIZE_W - PSH + 1;

  state_t state_r, state_nxt;
  logic [ADDR_W-1:0] base_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W:0] idx_r, idx_nxt, k_r, k_nxt;
  logic mode_r, mode_nxt;
  logic [PGS_W-1:0] pages_r, pages_nxt;
  logic [ADDR_W-1:0] faddr_r, faddr_nxt;
  span_t cur_r, cur_nxt, prv_r, prv_nxt, hold_r, hold_nxt;
  logic [2:0] st_r, st_nxt;
  logic [ADDR_W-1:0] res_r, res_nxt;
  logic ovld_r, ovld_nxt;
  logic nb_r, nb_nxt; // 0 left neighbour, 1 right
  logic have_prv_r, have_prv_nxt;

  logic ram_we;
  logic [IDX_W-1:0] ram_addr;
  span_t ram_wd, ram_rd;
  logic [SPAN_W-1:0] ram_rd_bits;

  // reset entry 0 held outside the RAM until the first write
  logic e0_ok_r, e0_ok_nxt;
  span_t rd_s;
  logic [IDX_W-1:0] rd_addr_r;

  ffra_ram #(.WIDTH(SPAN_W), .DEPTH(MAX_SPANS)) u_span_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wd), .rdata(ram_rd_bits)
  );
  assign ram_rd = span_t'(ram_rd_bits);

  always_comb begin
    rd_s = ram_rd;
    if (rd_addr_r == '0 && !e0_ok_r) begin
      rd_s.start_pg = '0;
      rd_s.end_pg   = PAGE_W'(REGION_PAGES);
      rd_s.is_free  = 1'b1;
    end
  end

  function automatic logic [ADDR_W-1:0] pg_addr(input logic [ADDR_W-1:0] b,
                                                input logic [PAGE_W-1:0] p);
    logic [ADDR_W-1:0] o;
    o = ADDR_W'(p) << PSH;
    return b + o;
  endfunction

  logic [PAGE_W:0] span_len;
  assign span_len = {1'b0, cur_r.end_pg} - {1'b0, cur_r.start_pg};

  assign in_tready = (state_r == S_IDLE) && !ovld_r;
  assign cfg_ready = 1'b1;
  assign out_tvalid = ovld_r;
  assign out_tdata = {5'd0, res_r, st_r};

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= CNT_W'(1);
      ovld_r  <= 1'b0;
      e0_ok_r <= 1'b0;
      base_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovld_r  <= ovld_nxt;
      e0_ok_r <= e0_ok_nxt;
      if (cfg_valid) base_r <= cfg_data;
    end
    idx_r <= idx_nxt; k_r <= k_nxt; mode_r <= mode_nxt; pages_r <= pages_nxt;
    faddr_r <= faddr_nxt; cur_r <= cur_nxt; prv_r <= prv_nxt; hold_r <= hold_nxt;
    st_r <= st_nxt; res_r <= res_nxt; nb_r <= nb_nxt; have_prv_r <= have_prv_nxt;
    rd_addr_r <= ram_addr;
  end

  // sequencer
  always_comb begin
    logic [SIZE_W:0] sz;
    state_nxt = state_r; cnt_nxt = cnt_r; ovld_nxt = ovld_r; e0_ok_nxt = e0_ok_r;
    idx_nxt = idx_r; k_nxt = k_r; mode_nxt = mode_r; pages_nxt = pages_r;
    faddr_nxt = faddr_r; cur_nxt = cur_r; prv_nxt = prv_r; hold_nxt = hold_r;
    st_nxt = st_r; res_nxt = res_r; nb_nxt = nb_r; have_prv_nxt = have_prv_r;
    ram_we = 1'b0; ram_addr = idx_r[IDX_W-1:0]; ram_wd = cur_r;
    sz = '0;
    if (ovld_r && out_tready) ovld_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          mode_nxt  = in_tuser;
          sz        = {1'b0, in_tdata[31:0]} + (SIZE_W+1)'(PAGE_BYTES - 1);
          pages_nxt = PGS_W'(sz >> PSH);
          faddr_nxt = in_tdata[79:32];
          st_nxt    = ST_OK;
          res_nxt   = '0;
          idx_nxt   = '0;
          if (!in_tuser && in_tdata[31:0] == '0) st_nxt = ST_BAD_SIZE;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st_r != ST_OK ||
            (!mode_r && pages_r > PGS_W'(REGION_PAGES))) begin
          st_nxt = ST_BAD_SIZE;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SRCH_RD;
        end
      end
      S_SRCH_RD: begin
        if (idx_r >= (IDX_W+1)'(cnt_r)) begin
          st_nxt = mode_r ? ST_INVALID : ST_NO_FIT;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SRCH_EV;
        end
      end
      S_SRCH_EV: begin
        cur_nxt = rd_s;
        state_nxt = S_SPLIT;
        if (!mode_r) begin
          if (!(rd_s.is_free && ({1'b0, rd_s.end_pg} - {1'b0, rd_s.start_pg})
                >= (PAGE_W+1)'(pages_r))) begin
            idx_nxt = idx_r + 1'b1;
            state_nxt = S_SRCH_RD;
          end
        end else if (pg_addr(base_r, rd_s.start_pg) != faddr_r) begin
          prv_nxt = rd_s;
          idx_nxt = idx_r + 1'b1;
          state_nxt = S_SRCH_RD;
        end
        have_prv_nxt = (idx_r != '0);
      end
      S_SPLIT: begin
        if (!mode_r) begin
          if (span_len == (PAGE_W+1)'(pages_r)) begin
            ram_we = 1'b1; ram_wd = cur_r; ram_wd.is_free = 1'b0;
            if (idx_r == '0) e0_ok_nxt = 1'b1;
            res_nxt = pg_addr(base_r, cur_r.start_pg);
            state_nxt = S_DONE;
          end else if (cnt_r >= CNT_W'(MAX_SPANS)) begin
            st_nxt = ST_FULL; state_nxt = S_DONE;
          end else begin
            k_nxt = (IDX_W+1)'(cnt_r);
            state_nxt = S_SHR_RD;
          end
        end else if (cur_r.is_free) begin
          st_nxt = ST_DOUBLE; state_nxt = S_DONE;
        end else begin
          cur_nxt.is_free = 1'b1;
          nb_nxt = 1'b0;
          if (have_prv_r && prv_r.is_free && prv_r.end_pg == cur_r.start_pg) begin
            // merge into left neighbour, then drop entry idx
            idx_nxt = idx_r - 1'b1;
            cur_nxt.start_pg = prv_r.start_pg;
            k_nxt = idx_r;
            cnt_nxt = cnt_r - 1'b1;
            nb_nxt = 1'b0;
            state_nxt = S_SHL_RD;
          end else begin
            k_nxt = idx_r + 1'b1;
            nb_nxt = 1'b1;
            state_nxt = S_NB_RD;
          end
        end
      end
      // shift entries [idx+1, cnt) up one place, top first
      S_SHR_RD: begin
        if (k_r == idx_r + 1'b1) begin
          ram_we = 1'b1; ram_addr = idx_r[IDX_W-1:0];
          ram_wd.start_pg = cur_r.start_pg;
          ram_wd.end_pg = cur_r.start_pg + PAGE_W'(pages_r);
          ram_wd.is_free = 1'b0;
          if (idx_r == '0) e0_ok_nxt = 1'b1;
          hold_nxt.start_pg = cur_r.start_pg + PAGE_W'(pages_r);
          hold_nxt.end_pg = cur_r.end_pg;
          hold_nxt.is_free = 1'b1;
          res_nxt = pg_addr(base_r, cur_r.start_pg);
          cnt_nxt = cnt_r + 1'b1;
          state_nxt = S_SHR_WR;
        end else begin
          ram_addr = IDX_W'(k_r - 1'b1);
          state_nxt = S_SHR_WR;
        end
      end
      S_SHR_WR: begin
        ram_we = 1'b1; ram_addr = k_r[IDX_W-1:0];
        if (k_r == idx_r + 1'b1) begin
          ram_wd = hold_r;
          state_nxt = S_DONE;
        end else begin
          ram_wd = rd_s;
          k_nxt = k_r - 1'b1;
          state_nxt = S_SHR_RD;
        end
      end
      // right-neighbour check for free
      S_NB_RD: begin
        ram_addr = k_r[IDX_W-1:0];
        if (k_r >= (IDX_W+1)'(cnt_r)) begin
          ram_we = 1'b1; ram_addr = idx_r[IDX_W-1:0]; ram_wd = cur_r;
          if (idx_r == '0) e0_ok_nxt = 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_NB_EV;
        end
      end
      S_NB_EV: begin
        if (rd_s.is_free && cur_r.end_pg == rd_s.start_pg) begin
          cur_nxt.end_pg = rd_s.end_pg;
          cnt_nxt = cnt_r - 1'b1;
          state_nxt = S_SHL_RD;
        end else begin
          ram_we = 1'b1; ram_addr = idx_r[IDX_W-1:0]; ram_wd = cur_r;
          if (idx_r == '0) e0_ok_nxt = 1'b1;
          state_nxt = S_DONE;
        end
      end
      // drop entry k: move [k+1, cnt_old) down one place
      S_SHL_RD: begin
        if (k_r >= (IDX_W+1)'(cnt_r)) begin
          if (!nb_r) begin
            k_nxt = idx_r + 1'b1;
            nb_nxt = 1'b1;
            state_nxt = S_NB_RD;
          end else begin
            ram_we = 1'b1; ram_addr = idx_r[IDX_W-1:0]; ram_wd = cur_r;
            if (idx_r == '0) e0_ok_nxt = 1'b1;
            state_nxt = S_DONE;
          end
        end else begin
          ram_addr = IDX_W'(k_r + 1'b1);
          state_nxt = S_SHL_WR;
        end
      end
      S_SHL_WR: begin
        ram_we = 1'b1; ram_addr = k_r[IDX_W-1:0]; ram_wd = rd_s;
        if (k_r == '0) e0_ok_nxt = 1'b1;
        k_nxt = k_r + 1'b1;
        state_nxt = S_SHL_RD;
      end
      S_DONE: begin
        if (st_r != ST_OK) res_nxt = '0;
        ovld_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

/* hdl/ffra_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module ffra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, and registered read (old data on a write)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* bench/ffra_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_checker
// Watches the request, result and base-address channels of the allocator,
// keeps its own span table, predicts each status and address and compares
// them in order with what the block returns.
// ----------------------------------------------------------------------------
module ffra_checker #(
  parameter int REGION_PAGES = 32768,
  parameter int MAX_SPANS    = 64,
  parameter int PAGE_BYTES   = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic        in_tuser,
  input  logic [79:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [47:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  import ffra_pkg::*;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] addr;
  } alloc_result_t;

  // shadow span table
  logic [ADDR_W-1:0] base_addr;
  int unsigned       pg_start [MAX_SPANS];
  int unsigned       pg_end   [MAX_SPANS];
  bit                pg_free  [MAX_SPANS];
  int unsigned       n_spans;
  alloc_result_t     result_q [$];

  function automatic logic [ADDR_W-1:0] page_to_addr(int unsigned pg);
    logic [63:0] a;
    a = {16'd0, base_addr} + 64'(pg) * 64'(PAGE_BYTES);
    return a[ADDR_W-1:0];
  endfunction

  function automatic void drop_span(int unsigned idx);
    for (int unsigned k = idx; k + 1 < n_spans; k++) begin
      pg_start[k] = pg_start[k+1];
      pg_end[k]   = pg_end[k+1];
      pg_free[k]  = pg_free[k+1];
    end
    n_spans--;
  endfunction

  function automatic alloc_result_t alloc_span(logic [SIZE_W-1:0] bytes);
    alloc_result_t r;
    logic [63:0]   pages;
    int unsigned   i;
    r = '{status: ST_OK, addr: '0};
    if (bytes == 0) begin
      r.status = ST_BAD_SIZE;
      return r;
    end
    pages = ({32'd0, bytes} + 64'(PAGE_BYTES) - 1) / 64'(PAGE_BYTES);
    if (pages > 64'(REGION_PAGES)) begin
      r.status = ST_BAD_SIZE;
      return r;
    end
    for (i = 0; i < n_spans; i++)
      if (pg_free[i] && 64'(pg_end[i] - pg_start[i]) >= pages) break;
    if (i >= n_spans) begin
      r.status = ST_NO_FIT;
      return r;
    end
    if (64'(pg_end[i] - pg_start[i]) != pages) begin
      if (n_spans >= MAX_SPANS) begin
        r.status = ST_FULL;
        return r;
      end
      for (int unsigned k = n_spans; k > i + 1; k--) begin
        pg_start[k] = pg_start[k-1];
        pg_end[k]   = pg_end[k-1];
        pg_free[k]  = pg_free[k-1];
      end
      pg_start[i+1] = pg_start[i] + int'(pages);
      pg_end[i+1]   = pg_end[i];
      pg_free[i+1]  = 1'b1;
      pg_end[i]     = pg_start[i+1];
      n_spans++;
    end
    pg_free[i] = 1'b0;
    r.addr = page_to_addr(pg_start[i]);
    return r;
  endfunction

  function automatic alloc_result_t release_span(logic [ADDR_W-1:0] addr);
    alloc_result_t r;
    int unsigned   i;
    r = '{status: ST_OK, addr: '0};
    for (i = 0; i < n_spans; i++)
      if (page_to_addr(pg_start[i]) == addr) break;
    if (i >= n_spans) begin
      r.status = ST_INVALID;
      return r;
    end
    if (pg_free[i]) begin
      r.status = ST_DOUBLE;
      return r;
    end
    pg_free[i] = 1'b1;
    // merge with the lower neighbor
    if (i > 0 && pg_free[i-1] && pg_end[i-1] == pg_start[i]) begin
      pg_end[i-1] = pg_end[i];
      drop_span(i);
      i--;
    end
    // merge with the upper neighbor
    if (i + 1 < n_spans && pg_free[i+1] && pg_end[i] == pg_start[i+1]) begin
      pg_end[i] = pg_end[i+1];
      drop_span(i + 1);
    end
    return r;
  endfunction

  assign pending = result_q.size();

  always @(posedge clk) begin
    alloc_result_t want;
    alloc_result_t got;
    if (!rst_n) begin
      base_addr = '0;
      pg_start[0] = 0;
      pg_end[0]   = REGION_PAGES;
      pg_free[0]  = 1'b1;
      n_spans = 1;
      result_q.delete();
      fail_count <= 0;
    end else begin
      // base address transfer
      if (cfg_valid && cfg_ready) base_addr = cfg_data;
      // request transfer
      if (in_tvalid && in_tready) begin
        if (in_tuser) result_q.push_back(release_span(in_tdata[79:32]));
        else          result_q.push_back(alloc_span(in_tdata[31:0]));
      end
      // result transfer
      if (out_tvalid && out_tready) begin
        got.status = status_t'(out_tdata[2:0]);
        got.addr   = out_tdata[50:3];
        if (result_q.size() == 0) begin
          $error("unexpected result: status %0d start_address %h", got.status, got.addr);
          fail_count <= fail_count + 1;
        end else begin
          want = result_q.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            fail_count <= fail_count + 1;
          end else if (got.addr !== want.addr) begin
            $error("start_address: expected %h, actual %h", want.addr, got.addr);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

/* bench/first_fit_range_allocator_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_range_allocator_test
// Drives allocate and free requests into the allocator under several region
// bases, with random gaps and output stalls; the checker judges the results.
// ----------------------------------------------------------------------------
module first_fit_range_allocator_test;
  import ffra_pkg::*;

  localparam int REGION_PAGES = 32768;
  localparam int PAGE_BYTES   = 4096;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic        in_tuser = 1'b0;
  logic [79:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [47:0] cfg_data = '0;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  bit          calm = 1'b0;
  logic [47:0] base_now = '0;
  logic [47:0] live_addrs [$];

  always #5 clk = ~clk;

  first_fit_range_allocator dut (.*);

  ffra_checker chk (.*);

  // run-length limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result-side stalls in short bursts
  always @(negedge clk) begin
    int burst;
    if (!calm && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      burst = $urandom_range(1, 3);
      repeat (burst - 1) @(negedge clk);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // collect granted addresses to free later
  always @(posedge clk)
    if (out_tvalid && out_tready && out_tdata[2:0] == ST_OK && out_tdata[50:3] != 0)
      live_addrs.push_back(out_tdata[50:3]);

  // valid stays up between back-to-back requests; it drops for a gap or a drain
  task automatic send_request(logic mode, logic [31:0] bytes, logic [47:0] addr);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser  <= mode;
    in_tdata  <= {addr, bytes};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_base(logic [47:0] base);
    drain_results();
    cfg_data  <= base;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    base_now = base;
    live_addrs.delete();
  endtask

  // free request: mostly a live span, sometimes an odd address
  task automatic random_free();
    int idx;
    logic [47:0] a;
    if (live_addrs.size() != 0 && $urandom_range(0, 9) < 8) begin
      idx = $urandom_range(0, live_addrs.size() - 1);
      a = live_addrs[idx];
      if ($urandom_range(0, 5) != 0) live_addrs.delete(idx);
    end else begin
      a = {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF;
      if ($urandom_range(0, 1)) a = base_now + 48'($urandom_range(0, REGION_PAGES)) * PAGE_BYTES;
    end
    send_request(MODE_FREE, $urandom, a);
  endtask

  task automatic random_alloc();
    logic [31:0] bytes;
    case ($urandom_range(0, 9))
      0:       bytes = $urandom;
      1:       bytes = 32'(PAGE_BYTES) * $urandom_range(1, 4);
      2:       bytes = $urandom_range(0, 3);
      3:       bytes = $urandom_range(1, 32'(REGION_PAGES) * PAGE_BYTES + 4096);
      default: bytes = $urandom_range(1, 16 * PAGE_BYTES);
    endcase
    send_request(MODE_ALLOC, bytes, {$urandom, $urandom});
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: size edges, whole region, exact fit, frees and errors
    send_request(MODE_ALLOC, 32'd0, '0);
    send_request(MODE_ALLOC, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_request(MODE_ALLOC, 32'(REGION_PAGES) * PAGE_BYTES + 1, '0);
    send_request(MODE_ALLOC, 32'(REGION_PAGES) * PAGE_BYTES, '0);
    send_request(MODE_ALLOC, 32'd1, '0);
    send_request(MODE_FREE, '0, 48'd0);
    send_request(MODE_FREE, '0, 48'd0);
    send_request(MODE_FREE, '0, 48'h123);
    send_request(MODE_ALLOC, 32'd1, '0);
    send_request(MODE_ALLOC, 32'd4097, '0);
    send_request(MODE_ALLOC, 32'd4096, '0);
    send_request(MODE_FREE, '0, 48'h1000);
    send_request(MODE_FREE, '0, 48'h0);
    send_request(MODE_FREE, '0, 48'h3000);
    send_request(MODE_FREE, '0, 48'hFFFF_FFFF_FFFF);
    // fill the table until splits are refused, then exact fits
    for (int i = 0; i < 66; i++) send_request(MODE_ALLOC, 32'd1, '0);
    send_request(MODE_ALLOC, 32'd8192, '0);
    send_request(MODE_FREE, '0, 48'h5000);
    send_request(MODE_ALLOC, 32'd4096, '0);

    // pause until every result is back, then change the base
    write_base(48'hFFFF_FFFF_F000);
    for (int i = 0; i < 40; i++) send_request(MODE_FREE, '0, 48'(i) * PAGE_BYTES);
    send_request(MODE_ALLOC, 32'd8192, '0);
    send_request(MODE_FREE, '0, 48'hFFFF_FFFF_F000);

    // random phases under several bases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_base(48'd0);
        1: write_base({$urandom, $urandom} & 48'hFFFF_FFFF_F000);
        2: write_base(48'hFFFF_FFF0_0000);
        default: write_base({$urandom_range(0, 65535), 32'h0});
      endcase
      if (ph == 3) calm = 1'b1;
      for (int i = 0; i < 80; i++) begin
        if ($urandom_range(0, 1)) random_alloc();
        else random_free();
      end
    end

    drain_results();
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
